// ===== rtl/scsd_pkg.sv =====
`default_nettype none

package scsd_pkg;

    // Field widths fixed by the item formats.
    localparam int SAMPLE_W   = 10;
    localparam int CMD_W      = 8;
    localparam int LIMIT_W    = 10;
    localparam int TOL_W      = 11;
    localparam int PHASE_W    = 2;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Datapath widths.
    // The scaled product (cur - nominal) * (tol_high - tol_low) stays below 2^21 in magnitude.
    localparam int PROD_W  = 22;
    localparam int TOLS_W  = PROD_W + 2;
    localparam int CMPS_W  = TOLS_W + 1;
    localparam int DEN_W   = 10;
    localparam int RD3_W   = SAMPLE_W + 2;

    // floor(s / 3) == (s * 43691) >> 17 for every s below 2^17.
    localparam int               RECIP3_W     = 16;
    localparam logic [RECIP3_W-1:0] RECIP3    = 16'd43691;
    localparam int               RECIP3_SHIFT = 17;

    localparam logic IN_OP_START  = 1'b0;
    localparam logic IN_OP_SAMPLE = 1'b1;

    localparam logic [PHASE_W-1:0] PH_WAIT    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MEASURE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DONE    = 2'd2;

    localparam logic [DIR_W-1:0] DIR_NONE  = 2'b00;
    localparam logic [DIR_W-1:0] DIR_OPEN  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_CLOSE = 2'b11;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_LOAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_HIGH   = 3'd5;

    localparam logic [CMD_W-1:0]    CENTER_RESET     = 8'd90;
    localparam logic [SAMPLE_W-1:0] STALL_LOAD_RESET = 10'd1023;
    localparam logic [SAMPLE_W-1:0] THRESH_SKIP      = 10'd1;

    // Microcode.
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;
    typedef logic [3:0]       uop_op_t;
    typedef logic [2:0]       uop_cond_t;

    typedef struct packed {
        uop_op_t   op;
        uop_cond_t cond;
        upc_t      target;
    } ucode_t;

    localparam uop_op_t UOP_NOP       = 4'd0;
    localparam uop_op_t UOP_CUR       = 4'd1;
    localparam uop_op_t UOP_MUL       = 4'd2;
    localparam uop_op_t UOP_DIVLD_TOL = 4'd3;
    localparam uop_op_t UOP_DIVSTEP   = 4'd4;
    localparam uop_op_t UOP_TOL       = 4'd5;
    localparam uop_op_t UOP_CMP       = 4'd6;
    localparam uop_op_t UOP_SEED      = 4'd7;
    localparam uop_op_t UOP_ACC       = 4'd8;
    localparam uop_op_t UOP_DIVLD_AVG = 4'd9;
    localparam uop_op_t UOP_AVG       = 4'd10;
    localparam uop_op_t UOP_EMIT      = 4'd11;

    localparam uop_cond_t COND_NEXT      = 3'd0;
    localparam uop_cond_t COND_ALWAYS    = 3'd1;
    localparam uop_cond_t COND_PREV_ZERO = 3'd2;
    localparam uop_cond_t COND_RANGE_EQ  = 3'd3;
    localparam uop_cond_t COND_DIV_BUSY  = 3'd4;

    localparam upc_t ST_ENTRY   = 4'd0;
    localparam upc_t ST_MUL     = 4'd1;
    localparam upc_t ST_DIVLD_T = 4'd2;
    localparam upc_t ST_DIV_T   = 4'd3;
    localparam upc_t ST_TOL     = 4'd4;
    localparam upc_t ST_CMP     = 4'd5;
    localparam upc_t ST_SEED    = 4'd6;
    localparam upc_t ST_ACC     = 4'd7;
    localparam upc_t ST_DIVLD_A = 4'd8;
    localparam upc_t ST_DIV_A   = 4'd9;
    localparam upc_t ST_AVG     = 4'd10;
    localparam upc_t ST_EMIT    = 4'd11;

    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t w;
        w = '{UOP_NOP, COND_NEXT, ST_ENTRY};
        case (pc)
            ST_ENTRY:   w = '{UOP_CUR,       COND_PREV_ZERO, ST_SEED};
            ST_MUL:     w = '{UOP_MUL,       COND_RANGE_EQ,  ST_TOL};
            ST_DIVLD_T: w = '{UOP_DIVLD_TOL, COND_NEXT,      ST_ENTRY};
            ST_DIV_T:   w = '{UOP_DIVSTEP,   COND_DIV_BUSY,  ST_DIV_T};
            ST_TOL:     w = '{UOP_TOL,       COND_NEXT,      ST_ENTRY};
            ST_CMP:     w = '{UOP_CMP,       COND_ALWAYS,    ST_ACC};
            ST_SEED:    w = '{UOP_SEED,      COND_NEXT,      ST_ENTRY};
            ST_ACC:     w = '{UOP_ACC,       COND_NEXT,      ST_ENTRY};
            ST_DIVLD_A: w = '{UOP_DIVLD_AVG, COND_NEXT,      ST_ENTRY};
            ST_DIV_A:   w = '{UOP_DIVSTEP,   COND_DIV_BUSY,  ST_DIV_A};
            ST_AVG:     w = '{UOP_AVG,       COND_NEXT,      ST_ENTRY};
            ST_EMIT:    w = '{UOP_EMIT,      COND_NEXT,      ST_ENTRY};
            default:    w = '{UOP_NOP,       COND_ALWAYS,    ST_EMIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scsd_feed_if.sv =====
`default_nettype none

interface scsd_feed_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [scsd_pkg::CMD_W-1:0]    drive_command;
    logic [scsd_pkg::LIMIT_W-1:0]  step_limit;
    logic                          stop_on_stall;
    logic [scsd_pkg::SAMPLE_W-1:0] reading_a;
    logic [scsd_pkg::SAMPLE_W-1:0] reading_b;
    logic [scsd_pkg::SAMPLE_W-1:0] reading_c;

    modport source (
        output valid, op, drive_command, step_limit, stop_on_stall,
               reading_a, reading_b, reading_c,
        input  ready
    );
    modport sink (
        input  valid, op, drive_command, step_limit, stop_on_stall,
               reading_a, reading_b, reading_c,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/scsd_report_if.sv =====
`default_nettype none

interface scsd_report_if;
    logic                                valid;
    logic                                ready;
    logic [scsd_pkg::PHASE_W-1:0]        phase;
    logic [scsd_pkg::SAMPLE_W-1:0]       average_load;
    logic [scsd_pkg::SAMPLE_W-1:0]       peak_current;
    logic                                stall_seen;
    logic signed [scsd_pkg::DIR_W-1:0]   stall_direction;
    logic                                move_done;

    modport source (
        output valid, phase, average_load, peak_current, stall_seen,
               stall_direction, move_done,
        input  ready
    );
    modport sink (
        input  valid, phase, average_load, peak_current, stall_seen,
               stall_direction, move_done,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/scsd_cfg_if.sv =====
`default_nettype none

interface scsd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [scsd_pkg::CFG_IDX_W-1:0]    index;
    logic [scsd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/servo_current_stall_detector_unit.sv =====
`default_nettype none

// Channel   Direction  Payload                                           Transfer when
// feed      in         op, drive_command, step_limit, stop_on_stall,     valid && ready
//                      reading_a, reading_b, reading_c
// report    out        phase, average_load, peak_current, stall_seen,    valid && ready
//                      stall_direction, move_done
// cfg       in         index, data                                       valid && ready
//
// A start item or an unmeasured sample skips the microprogram and goes to its emit step.
// A measured sample runs the microprogram, which uses the shared one-bit-per-cycle divider
// once for the tolerance scaling and once for the running average; a seeding sample or a flat
// load range skips the first division.
// Reset (rst_n low) puts the move in the finished phase and loads the register defaults.
// The result register lets feed accept the next item while a result waits on report;
// the sequencer holds at its final step only if that register is still full.

module servo_current_stall_detector_unit #(
    parameter int MAX_STEPS = 512
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    scsd_feed_if.sink          feed,
    scsd_report_if.source      report,
    scsd_cfg_if.sink           cfg
);

    localparam int STEP_CAP = (MAX_STEPS < 1023) ? MAX_STEPS : 1023;
    localparam int STEP_W   = $clog2(STEP_CAP + 1);
    localparam int SUM_W    = scsd_pkg::SAMPLE_W + STEP_W;
    localparam int DIV_W    = (SUM_W > scsd_pkg::PROD_W) ? SUM_W : scsd_pkg::PROD_W;
    localparam int CNT_W    = $clog2(DIV_W + 1);

    localparam int SW  = scsd_pkg::SAMPLE_W;
    localparam int DW  = scsd_pkg::DEN_W;
    localparam int PW  = scsd_pkg::PROD_W;
    localparam int TW  = scsd_pkg::TOLS_W;
    localparam int CW  = scsd_pkg::CMPS_W;

    // Configuration registers.
    logic [scsd_pkg::CMD_W-1:0]        center_reg;
    logic [SW-1:0]                     threshold_reg;
    logic [SW-1:0]                     nominal_reg;
    logic [SW-1:0]                     stall_load_reg;
    logic signed [scsd_pkg::TOL_W-1:0] tol_low_reg;
    logic signed [scsd_pkg::TOL_W-1:0] tol_high_reg;

    // Move state.
    logic [scsd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [SW-1:0]                prev_reg, prev_next;
    logic [SW-1:0]                peak_reg, peak_next;
    logic [SUM_W-1:0]             load_sum_reg, load_sum_next;
    logic [STEP_W-1:0]            steps_taken_reg, steps_taken_next;
    logic [STEP_W-1:0]            steps_wanted_reg, steps_wanted_next;
    logic [scsd_pkg::CMD_W-1:0]   move_cmd_reg, move_cmd_next;
    logic                         stall_en_reg, stall_en_next;
    logic [scsd_pkg::DIR_W-1:0]   stall_dir_reg, stall_dir_next;
    logic                         stall_bit_reg, stall_bit_next;
    logic [SW-1:0]                average_reg, average_next;
    logic                         done_reg, done_next;

    // Sequencer.
    logic                 busy_reg, busy_next;
    scsd_pkg::upc_t       step_reg, step_next;
    logic [CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    scsd_pkg::ucode_t     uop;
    logic                 take_jump;

    // Datapath registers.
    logic [SW-1:0]        read_a_reg, read_b_reg, read_c_reg;
    logic [SW-1:0]        cur_reg;
    logic [PW-1:0]        prod_mag_reg;
    logic                 neg_reg;
    logic [DW-1:0]        den_mag_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        divisor_reg;
    logic signed [TW-1:0] tol_reg;

    // Result register payload.
    logic [scsd_pkg::PHASE_W-1:0] out_phase_reg;
    logic [SW-1:0]                out_avg_reg;
    logic [SW-1:0]                out_peak_reg;
    logic                         out_stall_reg;
    logic [scsd_pkg::DIR_W-1:0]   out_dir_reg;
    logic                         out_done_reg;

    logic                         accept;
    logic                         emit_fire;
    logic [scsd_pkg::RD3_W-1:0]   read_sum;
    logic [scsd_pkg::RD3_W+scsd_pkg::RECIP3_W-1:0] recip_prod;
    logic signed [SW:0]           diff_cur;
    logic signed [SW:0]           diff_den;
    logic signed [scsd_pkg::TOL_W:0] diff_tol;
    logic signed [2*SW+2:0]       prod_full;
    logic [DW:0]                  trial;
    logic                         trial_ge;
    logic signed [TW-1:0]         quot_s;
    logic signed [CW-1:0]         drop_sum;

    assign accept    = feed.valid && feed.ready;
    assign feed.ready = !busy_reg;
    assign cfg.ready = 1'b1;
    assign uop       = scsd_pkg::ucode_rom(step_reg);
    assign emit_fire = busy_reg && (uop.op == scsd_pkg::UOP_EMIT)
                       && (!out_valid_reg || report.ready);

    // Average of three readings by reciprocal multiplication.
    assign read_sum   = scsd_pkg::RD3_W'(read_a_reg) + scsd_pkg::RD3_W'(read_b_reg)
                        + scsd_pkg::RD3_W'(read_c_reg);
    assign recip_prod = (scsd_pkg::RD3_W + scsd_pkg::RECIP3_W)'(read_sum)
                        * (scsd_pkg::RD3_W + scsd_pkg::RECIP3_W)'(scsd_pkg::RECIP3);

    assign diff_cur  = $signed({1'b0, cur_reg}) - $signed({1'b0, nominal_reg});
    assign diff_den  = $signed({1'b0, stall_load_reg}) - $signed({1'b0, nominal_reg});
    assign diff_tol  = $signed({tol_high_reg[scsd_pkg::TOL_W-1], tol_high_reg})
                       - $signed({tol_low_reg[scsd_pkg::TOL_W-1], tol_low_reg});
    assign prod_full = (2*SW+3)'(diff_cur) * (2*SW+3)'(diff_tol);

    // One restoring division step.
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, divisor_reg};

    assign quot_s   = $signed({{(TW-PW){1'b0}}, quo_reg[PW-1:0]});
    assign drop_sum = CW'($signed({1'b0, prev_reg})) - CW'($signed({1'b0, cur_reg}))
                      + CW'(tol_reg);

    always_comb
    begin
        case (uop.cond)
            scsd_pkg::COND_NEXT:      take_jump = 1'b0;
            scsd_pkg::COND_ALWAYS:    take_jump = 1'b1;
            scsd_pkg::COND_PREV_ZERO: take_jump = (prev_reg == '0);
            scsd_pkg::COND_RANGE_EQ:  take_jump = (nominal_reg == stall_load_reg);
            scsd_pkg::COND_DIV_BUSY:  take_jump = (div_cnt_reg != CNT_W'(1));
            default:                  take_jump = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        prev_next         = prev_reg;
        peak_next         = peak_reg;
        load_sum_next     = load_sum_reg;
        steps_taken_next  = steps_taken_reg;
        steps_wanted_next = steps_wanted_reg;
        move_cmd_next     = move_cmd_reg;
        stall_en_next     = stall_en_reg;
        stall_dir_next    = stall_dir_reg;
        stall_bit_next    = stall_bit_reg;
        average_next      = average_reg;
        done_next         = done_reg;
        busy_next         = busy_reg;
        step_next         = step_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg && !report.ready;

        if (accept)
        begin
            busy_next = 1'b1;
            step_next = scsd_pkg::ST_EMIT;
            done_next = 1'b0;
            if (feed.op == scsd_pkg::IN_OP_START)
            begin
                move_cmd_next = feed.drive_command;
                if (32'(feed.step_limit) > 32'(STEP_CAP))
                begin
                    steps_wanted_next = STEP_W'(STEP_CAP);
                end
                else
                begin
                    steps_wanted_next = feed.step_limit[STEP_W-1:0];
                end
                stall_en_next    = feed.stop_on_stall;
                prev_next        = '0;
                peak_next        = '0;
                load_sum_next    = '0;
                steps_taken_next = '0;
                stall_dir_next   = scsd_pkg::DIR_NONE;
                average_next     = '0;
                stall_bit_next   = 1'b0;
                if (threshold_reg <= scsd_pkg::THRESH_SKIP)
                begin
                    phase_next = scsd_pkg::PH_MEASURE;
                    if (steps_wanted_next == '0)
                    begin
                        phase_next = scsd_pkg::PH_DONE;
                        done_next  = 1'b1;
                    end
                end
                else
                begin
                    phase_next = scsd_pkg::PH_WAIT;
                end
            end
            else
            begin
                case (phase_reg)
                    scsd_pkg::PH_WAIT:
                    begin
                        if (feed.reading_a >= threshold_reg)
                        begin
                            phase_next = scsd_pkg::PH_MEASURE;
                            if (steps_wanted_reg == '0)
                            begin
                                phase_next = scsd_pkg::PH_DONE;
                                done_next  = 1'b1;
                            end
                        end
                    end
                    scsd_pkg::PH_MEASURE:
                    begin
                        step_next = scsd_pkg::ST_ENTRY;
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
        end
        else if (busy_reg)
        begin
            step_next = take_jump ? uop.target : step_reg + scsd_pkg::UPC_W'(1);
            case (uop.op)
                scsd_pkg::UOP_DIVLD_TOL, scsd_pkg::UOP_DIVLD_AVG:
                begin
                    div_cnt_next = CNT_W'(DIV_W);
                end
                scsd_pkg::UOP_DIVSTEP:
                begin
                    div_cnt_next = div_cnt_reg - CNT_W'(1);
                end
                scsd_pkg::UOP_CMP:
                begin
                    if (cur_reg > peak_reg)
                    begin
                        peak_next = cur_reg;
                    end
                    prev_next = cur_reg;
                    if (stall_en_reg && drop_sum[CW-1])
                    begin
                        stall_bit_next = 1'b1;
                        if (move_cmd_reg < center_reg)
                        begin
                            stall_dir_next = scsd_pkg::DIR_OPEN;
                        end
                        else if (move_cmd_reg > center_reg)
                        begin
                            stall_dir_next = scsd_pkg::DIR_CLOSE;
                        end
                    end
                end
                scsd_pkg::UOP_SEED:
                begin
                    prev_next = cur_reg;
                end
                scsd_pkg::UOP_ACC:
                begin
                    load_sum_next    = load_sum_reg + SUM_W'(prev_reg);
                    steps_taken_next = steps_taken_reg + STEP_W'(1);
                end
                scsd_pkg::UOP_AVG:
                begin
                    average_next = quo_reg[SW-1:0];
                    if (stall_bit_reg || (steps_taken_reg >= steps_wanted_reg))
                    begin
                        phase_next = scsd_pkg::PH_DONE;
                        done_next  = 1'b1;
                    end
                end
                scsd_pkg::UOP_EMIT:
                begin
                    step_next = step_reg;
                    if (emit_fire)
                    begin
                        busy_next      = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg     <= scsd_pkg::CENTER_RESET;
            threshold_reg  <= '0;
            nominal_reg    <= '0;
            stall_load_reg <= scsd_pkg::STALL_LOAD_RESET;
            tol_low_reg    <= '0;
            tol_high_reg   <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                scsd_pkg::REG_CENTER:     center_reg     <= cfg.data[scsd_pkg::CMD_W-1:0];
                scsd_pkg::REG_THRESHOLD:  threshold_reg  <= cfg.data[SW-1:0];
                scsd_pkg::REG_NOMINAL:    nominal_reg    <= cfg.data[SW-1:0];
                scsd_pkg::REG_STALL_LOAD: stall_load_reg <= cfg.data[SW-1:0];
                scsd_pkg::REG_TOL_LOW:    tol_low_reg    <= $signed(cfg.data);
                scsd_pkg::REG_TOL_HIGH:   tol_high_reg   <= $signed(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= scsd_pkg::PH_DONE;
            prev_reg         <= '0;
            peak_reg         <= '0;
            load_sum_reg     <= '0;
            steps_taken_reg  <= '0;
            steps_wanted_reg <= '0;
            move_cmd_reg     <= '0;
            stall_en_reg     <= 1'b0;
            stall_dir_reg    <= scsd_pkg::DIR_NONE;
            stall_bit_reg    <= 1'b0;
            average_reg      <= '0;
            done_reg         <= 1'b0;
            busy_reg         <= 1'b0;
            step_reg         <= scsd_pkg::ST_ENTRY;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            prev_reg         <= prev_next;
            peak_reg         <= peak_next;
            load_sum_reg     <= load_sum_next;
            steps_taken_reg  <= steps_taken_next;
            steps_wanted_reg <= steps_wanted_next;
            move_cmd_reg     <= move_cmd_next;
            stall_en_reg     <= stall_en_next;
            stall_dir_reg    <= stall_dir_next;
            stall_bit_reg    <= stall_bit_next;
            average_reg      <= average_next;
            done_reg         <= done_next;
            busy_reg         <= busy_next;
            step_reg         <= step_next;
            div_cnt_reg      <= div_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Datapath driven by the current control word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_a_reg <= feed.reading_a;
            read_b_reg <= feed.reading_b;
            read_c_reg <= feed.reading_c;
        end
        if (busy_reg)
        begin
            case (uop.op)
                scsd_pkg::UOP_CUR:
                begin
                    cur_reg <= recip_prod[scsd_pkg::RECIP3_SHIFT +: SW];
                end
                scsd_pkg::UOP_MUL:
                begin
                    prod_mag_reg <= prod_full[2*SW+2] ? PW'(-prod_full) : PW'(prod_full);
                    neg_reg      <= prod_full[2*SW+2] ^ diff_den[SW];
                    den_mag_reg  <= diff_den[SW] ? DW'(-diff_den) : DW'(diff_den);
                end
                scsd_pkg::UOP_DIVLD_TOL:
                begin
                    quo_reg     <= DIV_W'(prod_mag_reg);
                    rem_reg     <= '0;
                    divisor_reg <= den_mag_reg;
                end
                scsd_pkg::UOP_DIVLD_AVG:
                begin
                    quo_reg     <= DIV_W'(load_sum_reg);
                    rem_reg     <= '0;
                    divisor_reg <= DW'(steps_taken_reg);
                end
                scsd_pkg::UOP_DIVSTEP:
                begin
                    rem_reg <= trial_ge ? DW'(trial - {1'b0, divisor_reg}) : trial[DW-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], trial_ge};
                end
                scsd_pkg::UOP_TOL:
                begin
                    if (nominal_reg == stall_load_reg)
                    begin
                        tol_reg <= TW'(tol_low_reg);
                    end
                    else
                    begin
                        tol_reg <= (neg_reg ? -quot_s : quot_s) + TW'(tol_low_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (emit_fire)
        begin
            out_phase_reg <= phase_reg;
            out_avg_reg   <= average_reg;
            out_peak_reg  <= peak_reg;
            out_stall_reg <= stall_bit_reg;
            out_dir_reg   <= stall_dir_reg;
            out_done_reg  <= done_reg;
        end
    end

    assign report.valid           = out_valid_reg;
    assign report.phase           = out_phase_reg;
    assign report.average_load    = out_avg_reg;
    assign report.peak_current    = out_peak_reg;
    assign report.stall_seen      = out_stall_reg;
    assign report.stall_direction = $signed(out_dir_reg);
    assign report.move_done       = out_done_reg;

    // The microprogram never runs past its final step.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= scsd_pkg::ST_EMIT))
        else $error("sequencer step out of program");

    // A stall direction is only recorded together with the stall flag.
    a_dir_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (stall_dir_reg != scsd_pkg::DIR_NONE) |-> stall_bit_reg)
        else $error("stall direction without stall");

    // Measured samples never overrun the requested count.
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_taken_reg <= steps_wanted_reg)
        else $error("step count overrun");

    // The divider has finished whenever its quotient is consumed.
    a_div_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ((uop.op == scsd_pkg::UOP_TOL) || (uop.op == scsd_pkg::UOP_AVG)))
        |-> (div_cnt_reg == '0))
        else $error("quotient used before division finished");

    // A new result only appears at the end of a sequencer run.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(report.valid) |-> $past(busy_reg))
        else $error("result without a finished item");

endmodule

`default_nettype wire
